FILE: rtl/tpc_pkg.sv
// Shared types and constants of the TCP port classifier.
`default_nettype none
package tpc_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int GATE_LIMIT    = 8192;
   localparam int GATE_W        = 14;
   localparam int PORT_W        = 16;
   localparam int REQ_GATE_W    = 16;
   localparam int PROTO_W       = 8;

   localparam logic [PROTO_W-1:0]    TCP_PROTO      = 8'd6;
   localparam logic [REQ_GATE_W:0]   GATE_LIMIT_EXT = (REQ_GATE_W + 1)'(GATE_LIMIT);
   localparam logic [GATE_W-1:0]     DISCARD_GATE   = GATE_W'(GATE_LIMIT);

   typedef enum logic [1:0] {
      REQ_CLASSIFY = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_CLEAR    = 2'd2
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_GATE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // Request token that walks down the row of table cells.
   typedef struct packed {
      logic                vld;
      logic                nop;
      req_type_type        op;
      logic                tcp;
      logic [PORT_W-1:0]   port;
      logic [GATE_W-1:0]   gate;
      logic                done;
      logic                matched;
      status_type          status;
   } token_type;

endpackage
`default_nettype wire

FILE: rtl/tpc_if.sv
// Request and response channel interfaces of the TCP port classifier.
`default_nettype none
interface tpc_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         req_type;
   logic [tpc_pkg::PROTO_W-1:0]        ip_protocol;
   logic [tpc_pkg::PORT_W-1:0]         dest_port;
   logic [tpc_pkg::REQ_GATE_W-1:0]     entry_gate;

   modport source (output valid, output req_type, output ip_protocol, output dest_port,
                   output entry_gate, input ready);
   modport sink   (input valid, input req_type, input ip_protocol, input dest_port,
                   input entry_gate, output ready);
endinterface

interface tpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tpc_pkg::GATE_W-1:0]   out_gate;
   logic                         matched;
   logic [1:0]                   status;

   modport source (output valid, output out_gate, output matched, output status,
                   input ready);
   modport sink   (input valid, input out_gate, input matched, input status,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/tpc_cell.sv
// One table entry cell: holds a port key and gate, acts on the passing request.
`default_nettype none
module tpc_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire tpc_pkg::token_type tok_i,
   output tpc_pkg::token_type      tok_o
);

   logic                          valid_ff, valid_in;
   logic [tpc_pkg::PORT_W-1:0]    key_ff, key_in;
   logic [tpc_pkg::GATE_W-1:0]    gate_ff, gate_in;
   tpc_pkg::token_type            tok_ff, tok_in;
   logic                          hit;

   assign hit = valid_ff && (key_ff == tok_i.port);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      gate_in  = gate_ff;
      tok_in   = tok_i;
      if (tok_i.vld && !tok_i.nop) begin
         case (tok_i.op)
            tpc_pkg::REQ_CLASSIFY: begin
               if (!tok_i.done && tok_i.tcp && hit) begin
                  tok_in.gate    = gate_ff;
                  tok_in.matched = 1'b1;
                  tok_in.done    = 1'b1;
               end
            end
            tpc_pkg::REQ_ADD: begin
               // entries fill from the front, so the first free cell ends the search
               if (!tok_i.done && hit) begin
                  gate_in     = tok_i.gate;
                  tok_in.done = 1'b1;
               end else if (!tok_i.done && !valid_ff) begin
                  valid_in    = 1'b1;
                  key_in      = tok_i.port;
                  gate_in     = tok_i.gate;
                  tok_in.done = 1'b1;
               end
            end
            tpc_pkg::REQ_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
               tok_in = tok_i;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff  <= key_in;
         gate_ff <= gate_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

FILE: rtl/tcp_port_exact_match_classifier.sv
// Top level of the TCP destination-port exact-match classifier.
// The table is a row of 64 cells, one entry each. Every request enters an
// entry register and then moves one cell per cycle down the row while the
// row advances; each cell compares and updates its own entry as the request
// passes, and the last cell hands the request to an output register. A new
// request is taken every cycle unless the row holds. When the output
// register is full and the response side is not ready, the whole row holds
// and req_chan ready drops. Because only a clear empties the table, valid
// entries always form a prefix of the row, so an add that finds neither its
// port nor a free cell before the first free one cannot match later; it
// takes the first free cell, and if none is left the response reports table
// full. Classify requests for non-TCP packets and misses return the default
// gate register.
`default_nettype none
module tcp_port_exact_match_classifier (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tpc_req_if.sink                          req_chan,
   tpc_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_we,
   input  wire logic [tpc_pkg::GATE_W-1:0]  csr_wdata
);

   logic [tpc_pkg::GATE_W-1:0]  fallback_gate_ff;
   logic                        advance;
   tpc_pkg::token_type          entry_in;
   tpc_pkg::token_type          chain [0:tpc_pkg::TABLE_ENTRIES];
   tpc_pkg::token_type          last;
   logic                        rsp_vld_ff;
   logic [tpc_pkg::GATE_W-1:0]  rsp_gate_ff, rsp_gate_in;
   logic                        rsp_match_ff, rsp_match_in;
   tpc_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                        gate_ok;

   // Default gate register: reset to the drop gate.
   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_gate_ff <= tpc_pkg::DISCARD_GATE;
      end else if (csr_we) begin
         fallback_gate_ff <= csr_wdata;
      end
   end

   // Advance the row unless a finished response is stuck in the output register.
   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Accept only gates below the limit or equal to the drop gate.
   assign gate_ok = {1'b0, req_chan.entry_gate} <= tpc_pkg::GATE_LIMIT_EXT;

   // Build the token for the incoming request.
   always_comb begin
      entry_in         = '0;
      entry_in.vld     = req_chan.valid;
      entry_in.tcp     = req_chan.ip_protocol == tpc_pkg::TCP_PROTO;
      entry_in.port    = req_chan.dest_port;
      entry_in.status  = tpc_pkg::ST_OK;
      entry_in.op      = tpc_pkg::REQ_CLASSIFY;
      case (req_chan.req_type)
         tpc_pkg::REQ_CLASSIFY: begin
            entry_in.op   = tpc_pkg::REQ_CLASSIFY;
            entry_in.gate = fallback_gate_ff;
         end
         tpc_pkg::REQ_ADD: begin
            entry_in.op   = tpc_pkg::REQ_ADD;
            entry_in.gate = req_chan.entry_gate[tpc_pkg::GATE_W-1:0];
            if (!gate_ok) begin
               // rejected up front: leave the table untouched
               entry_in.done   = 1'b1;
               entry_in.status = tpc_pkg::ST_BAD_GATE;
            end
         end
         tpc_pkg::REQ_CLEAR: begin
            entry_in.op   = tpc_pkg::REQ_CLEAR;
            entry_in.done = 1'b1;
         end
         default: begin
            // unused code: pass through with all-zero response
            entry_in.nop  = 1'b1;
            entry_in.done = 1'b1;
         end
      endcase
   end

   // Entry register feeding the first cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].vld <= 1'b0;
      end else if (advance) begin
         chain[0] <= entry_in;
      end
   end

   // Row of table cells.
   for (genvar i = 0; i < tpc_pkg::TABLE_ENTRIES; i++) begin : g_cell
      tpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

   assign last = chain[tpc_pkg::TABLE_ENTRIES];

   // Turn the finished token into the response fields.
   always_comb begin
      rsp_gate_in   = '0;
      rsp_match_in  = 1'b0;
      rsp_status_in = tpc_pkg::ST_OK;
      if (!last.nop) begin
         case (last.op)
            tpc_pkg::REQ_CLASSIFY: begin
               rsp_gate_in  = last.gate;
               rsp_match_in = last.matched;
            end
            tpc_pkg::REQ_ADD: begin
               // no matching and no free cell found: table full
               rsp_status_in = last.done ? last.status : tpc_pkg::ST_FULL;
            end
            default: begin
               rsp_status_in = tpc_pkg::ST_OK;
            end
         endcase
      end
   end

   // Output register: hold the response until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_gate_ff   <= rsp_gate_in;
         rsp_match_ff  <= rsp_match_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.out_gate = rsp_gate_ff;
   assign rsp_chan.matched  = rsp_match_ff;
   assign rsp_chan.status   = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/tpc_checker.sv
// Port-level checks of the TCP port classifier, bound to the top level.
`default_nettype none
module tpc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tpc_pkg::GATE_W-1:0]  rsp_out_gate,
   input wire logic                        rsp_matched,
   input wire logic [1:0]                  rsp_status
);

   // a waiting response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a hit is always a successful classify
   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_status == tpc_pkg::ST_OK)
      else $error("matched response with error status");

   // rejected adds carry no gate and no hit
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tpc_pkg::ST_OK |-> rsp_out_gate == '0 && !rsp_matched)
      else $error("error response with gate or hit");

   // an empty output register never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind tcp_port_exact_match_classifier tpc_checker u_tpc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_gate (rsp_chan.out_gate),
   .rsp_matched  (rsp_chan.matched),
   .rsp_status   (rsp_chan.status)
);
`default_nettype wire
